// File: sv/drts_pkg.sv
// shared types, constants and the regime frequency table
package drts_pkg;

   localparam int unsigned NUM_REGIMES    = 4;
   localparam int unsigned PULSES_PER_REV = 2;
   localparam int unsigned TABLE_SIZE     = 4;
   localparam int unsigned NUM_ACTIVE     = (NUM_REGIMES < TABLE_SIZE) ? NUM_REGIMES : TABLE_SIZE;

   localparam int unsigned DUTY_W   = 10;
   localparam int unsigned HYST_W   = 8;
   localparam int unsigned REGIME_W = 3;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned FREQ_W   = 10;
   localparam int unsigned INDEX_W  = 3;

   localparam logic [HYST_W-1:0] HYST_MAX   = HYST_W'(200);
   localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(20);
   localparam int unsigned       FREQ_MAX   = 1023;

   // register indexes
   localparam logic [INDEX_W-1:0] REG_ENABLE = INDEX_W'(0);
   localparam logic [INDEX_W-1:0] REG_HYST   = INDEX_W'(1);
   localparam logic [INDEX_W-1:0] REG_THR_A  = INDEX_W'(2);
   localparam logic [INDEX_W-1:0] REG_THR_B  = INDEX_W'(3);
   localparam logic [INDEX_W-1:0] REG_THR_C  = INDEX_W'(4);
   localparam logic [INDEX_W-1:0] REG_THR_D  = INDEX_W'(5);

   // synthesizer actions
   localparam logic [ACTION_W-1:0] ACT_NONE  = ACTION_W'(0);
   localparam logic [ACTION_W-1:0] ACT_STOP  = ACTION_W'(1);
   localparam logic [ACTION_W-1:0] ACT_START = ACTION_W'(2);

   localparam logic [REGIME_W-1:0] REGIME_NONE = '0;
   localparam logic [REGIME_W-1:0] REGIME_MAX  = REGIME_W'(TABLE_SIZE);

   localparam logic [DUTY_W-1:0] THR_RESET [TABLE_SIZE] = '{
      DUTY_W'(430), DUTY_W'(480), DUTY_W'(530), DUTY_W'(560)
   };

   localparam int unsigned REGIME_RPM [TABLE_SIZE] = '{9000, 12000, 14000, 15600};

   // tach frequency for an rpm, rounded, held within 1..1023
   function automatic logic [FREQ_W-1:0] freq_of_rpm(input int unsigned rpm);
      int unsigned hz;
      hz = (rpm * PULSES_PER_REV + 30) / 60;
      if (hz == 0) begin
         hz = 1;
      end
      if (hz > FREQ_MAX) begin
         hz = FREQ_MAX;
      end
      return FREQ_W'(hz);
   endfunction

   localparam logic [FREQ_W-1:0] FREQ_TABLE [TABLE_SIZE] = '{
      freq_of_rpm(REGIME_RPM[0]), freq_of_rpm(REGIME_RPM[1]),
      freq_of_rpm(REGIME_RPM[2]), freq_of_rpm(REGIME_RPM[3])
   };

   typedef struct packed {
      logic              duty_valid;
      logic [DUTY_W-1:0] duty_tenths;
   } req_type;

   typedef struct packed {
      logic [REGIME_W-1:0] regime_now;
      logic                regime_changed;
      logic [ACTION_W-1:0] synth_action;
      logic [FREQ_W-1:0]   synth_freq_hz;
   } rsp_type;

   typedef struct packed {
      logic [INDEX_W-1:0] reg_index;
      logic [DUTY_W-1:0]  wdata;
   } csr_type;

   typedef struct packed {
      logic                               enable;
      logic [HYST_W-1:0]                  hyst;
      logic [TABLE_SIZE-1:0][DUTY_W-1:0]  thr;
   } cfg_type;

   typedef struct packed {
      logic [REGIME_W-1:0] regime;
      logic [FREQ_W-1:0]   last_freq;
      logic                running;
   } state_type;

endpackage

// File: sv/drts_chan_if.sv
// valid/ready channel carrying one payload per transfer
interface drts_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/drts_csr_regs.sv
// configuration registers with hysteresis clamp and enable-change clear
module drts_csr_regs (
   input  logic            clock,
   input  logic            reset,
   drts_chan_if.sink       csr_if,
   output drts_pkg::cfg_type cfg,
   output logic            state_clear
);
   import drts_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    clear_in;
   logic    wr;

   assign csr_if.ready = 1'b1;
   assign wr = csr_if.valid;

   always_comb begin
      cfg_in   = cfg_ff;
      clear_in = 1'b0;
      if (wr) begin
         case (csr_if.data.reg_index)
            REG_ENABLE: begin
               if (csr_if.data.wdata[0] != cfg_ff.enable) begin
                  cfg_in.enable = csr_if.data.wdata[0];
                  clear_in      = 1'b1;
               end
            end
            REG_HYST: begin
               cfg_in.hyst = (csr_if.data.wdata[HYST_W-1:0] > HYST_MAX) ?
                             HYST_MAX : csr_if.data.wdata[HYST_W-1:0];
            end
            REG_THR_A: cfg_in.thr[0] = csr_if.data.wdata;
            REG_THR_B: cfg_in.thr[1] = csr_if.data.wdata;
            REG_THR_C: cfg_in.thr[2] = csr_if.data.wdata;
            REG_THR_D: cfg_in.thr[3] = csr_if.data.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.hyst   <= HYST_RESET;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            cfg_ff.thr[i] <= THR_RESET[i];
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg         = cfg_ff;
   assign state_clear = clear_in;
endmodule

// File: sv/drts_regime_step.sv
// regime classification with hysteresis and synthesizer command for one sample
module drts_regime_step (
   input  drts_pkg::req_type   item,
   input  drts_pkg::cfg_type   cfg,
   input  drts_pkg::state_type cur,
   output drts_pkg::state_type nxt,
   output drts_pkg::rsp_type   result
);
   import drts_pkg::*;

   logic [REGIME_W-1:0] target;
   logic [DUTY_W-1:0]   entry;
   logic [DUTY_W-1:0]   exit_at;
   logic [REGIME_W-1:0] regime_sel;
   logic [FREQ_W-1:0]   freq;
   logic [FREQ_W-1:0]   last_eff;
   logic                changed;

   // highest regime whose entry the duty meets
   always_comb begin
      target = REGIME_NONE;
      for (int i = 0; i < NUM_ACTIVE; i++) begin
         if (item.duty_tenths >= cfg.thr[i]) begin
            target = REGIME_W'(i + 1);
         end
      end
   end

   always_comb begin
      entry = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (cur.regime == REGIME_W'(i + 1)) begin
            entry = cfg.thr[i];
         end
      end
   end

   // exit point floored at zero
   assign exit_at = ({2'b00, entry} > {{(DUTY_W - HYST_W + 2){1'b0}}, cfg.hyst}) ?
                    (entry - DUTY_W'(cfg.hyst)) : '0;

   always_comb begin
      regime_sel = cur.regime;
      if (target > cur.regime) begin
         regime_sel = target;
      end else if (target < cur.regime && cur.regime != REGIME_NONE &&
                   cur.regime <= REGIME_MAX && item.duty_tenths < exit_at) begin
         regime_sel = target;
      end
   end

   always_comb begin
      freq = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (regime_sel == REGIME_W'(i + 1)) begin
            freq = FREQ_TABLE[i];
         end
      end
   end

   assign changed  = (regime_sel != cur.regime);
   assign last_eff = changed ? '0 : cur.last_freq;

   always_comb begin
      nxt    = cur;
      result = '{regime_now: cur.regime, regime_changed: 1'b0,
                 synth_action: ACT_NONE, synth_freq_hz: '0};
      if (cfg.enable && item.duty_valid) begin
         nxt.regime                = regime_sel;
         nxt.last_freq             = last_eff;
         result.regime_now         = regime_sel;
         result.regime_changed     = changed;
         if (regime_sel == REGIME_NONE || regime_sel > REGIME_MAX || freq == '0) begin
            if (cur.running) begin
               nxt.running         = 1'b0;
               nxt.last_freq       = '0;
               result.synth_action = ACT_STOP;
            end else if (freq == '0 && regime_sel != REGIME_NONE) begin
               nxt.last_freq       = '0;
            end
         end else if (!(cur.running && freq == last_eff)) begin
            nxt.last_freq           = freq;
            nxt.running             = 1'b1;
            result.synth_action     = ACT_START;
            result.synth_freq_hz    = freq;
         end
      end
   end
endmodule

// File: sv/duty_regime_tach_selector.sv
// top level: duty sample regime selector driving a tach synthesizer
//
// channels: req_if carries one duty sample (duty_valid, duty_tenths) per transfer,
// rsp_if returns one result per sample (regime_now, regime_changed, synth_action,
// synth_freq_hz), csr_if writes the six configuration registers by index and is
// always ready.
// a sample transferred on req_if is registered in the input register, evaluated
// against the regime state, and its result is registered in the result register.
// throughput: one sample per cycle unless rsp_if stalls; the regime/frequency state
// update closes at evaluation, so each sample sees the state left by the one before.
// a stalled rsp_if holds the result register; req_if keeps taking a sample into
// the input register until that is full too, then ready drops.
// reset: clears both pipeline valids, the regime, last frequency and running flag,
// and loads the register reset values (disabled, hysteresis 20, thresholds 430,
// 480, 530, 560). writing enable with a new value clears the regime state.
module duty_regime_tach_selector (
   input logic          clock,
   input logic          reset,
   drts_chan_if.sink    req_if,
   drts_chan_if.source  rsp_if,
   drts_chan_if.sink    csr_if
);
   import drts_pkg::*;

   cfg_type   cfg;
   logic      state_clear;

   logic      s1_valid_ff;
   req_type   s1_item_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   state_type state_ff;

   state_type state_nxt;
   rsp_type   step_result;
   logic      advance;
   logic      req_xfer;

   drts_csr_regs u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_if      (csr_if),
      .cfg         (cfg),
      .state_clear (state_clear)
   );

   drts_regime_step u_step (
      .item   (s1_item_ff),
      .cfg    (cfg),
      .cur    (state_ff),
      .nxt    (state_nxt),
      .result (step_result)
   );

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_xfer     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= req_if.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || state_clear) begin
         state_ff <= '0;
      end else if (advance && s1_valid_ff) begin
         state_ff <= state_nxt;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;
endmodule

// File: sv/drts_checker.sv
// port-level checks on the result channel, bound to the top level
module drts_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input drts_pkg::rsp_type rsp_data
);
   import drts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_freq_only_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.synth_action == ACT_START) ==
                     (rsp_data.synth_freq_hz != '0)))
      else $error("frequency and start action disagree");

   a_legal_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.regime_now <= REGIME_MAX) &&
                    (rsp_data.synth_action == ACT_NONE ||
                     rsp_data.synth_action == ACT_STOP ||
                     rsp_data.synth_action == ACT_START))
      else $error("regime or action code out of range");
endmodule

bind duty_regime_tach_selector drts_checker u_drts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
